// ===== rtl/inverted_index_insert_defines.svh =====
// assertion macros for the inverted index insert block
`ifndef INVERTED_INDEX_INSERT_DEFINES_SVH
`define INVERTED_INDEX_INSERT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define IIX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IIX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/iix_pkg.sv =====
// shared types and constants for the inverted index insert block
`timescale 1ns / 1ps
package iix_pkg;
  localparam int unsigned MaxEntries     = 1024;
  localparam int unsigned MaxWordChars   = 128;
  localparam int unsigned MaxDocsPerWord = 128;

  localparam logic [2:0] StNew       = 3'd0;
  localparam logic [2:0] StAppended  = 3'd1;
  localparam logic [2:0] StPresent   = 3'd2;
  localparam logic [2:0] StTableFull = 3'd3;
  localparam logic [2:0] StListFull  = 3'd4;

  // one closed word handed from the front to the back
  typedef struct packed {
    logic [15:0] doc_id;
    logic [7:0]  length;
    logic        truncated;
    logic        bank;
  } word_job_t;
endpackage

// ===== rtl/inverted_index_insert.sv =====
// top level of the inverted index insert block
`timescale 1ns / 1ps
// Bytes are taken one per cycle, while in_ready_o is high, into one half of a
// two-word buffer; a closed word passes through a one-entry queue to the
// search engine, so the next word loads while the previous one is searched.
// The search time of a closed word grows with each stored entry of other
// length, each byte of entries of equal length and each listed id of the
// matched entry (or each byte of a new word to store); the single read port
// of each table memory sets this cost. Stores need no clearing after reset.
module inverted_index_insert #(
  parameter int unsigned MaxEntries     = iix_pkg::MaxEntries,
  parameter int unsigned MaxWordChars   = iix_pkg::MaxWordChars,
  parameter int unsigned MaxDocsPerWord = iix_pkg::MaxDocsPerWord
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] doc_id_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  entry_index_o,
  output logic [2:0]  insert_status_o,
  output logic        word_truncated_o
);
  localparam int unsigned CW = (MaxWordChars > 1) ? $clog2(MaxWordChars) : 1;

  logic               buf_we, job_valid, job_ready, busy_bank, busy;
  logic [CW:0]        buf_waddr, buf_raddr;
  logic [7:0]         buf_wdata, buf_rdata;
  iix_pkg::word_job_t job;

  iix_front #(.MaxWordChars(MaxWordChars)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_code_i, .doc_id_i,
    .last_char_i, .buf_we_o(buf_we), .buf_waddr_o(buf_waddr),
    .buf_wdata_o(buf_wdata), .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_o(job), .bank_free_i(!(busy && busy_bank == buf_waddr[CW])));

  iix_ram #(.Width(8), .Depth(2 * (1 << CW))) u_buf (
    .clk_i, .we_i(buf_we), .waddr_i(buf_waddr), .wdata_i(buf_wdata),
    .raddr_i(buf_raddr), .rdata_o(buf_rdata));

  iix_back #(
    .MaxEntries(MaxEntries), .MaxWordChars(MaxWordChars),
    .MaxDocsPerWord(MaxDocsPerWord)
  ) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .busy_bank_o(busy_bank), .busy_o(busy),
    .buf_raddr_o(buf_raddr), .buf_rdata_i(buf_rdata), .out_valid_o,
    .out_ready_i, .entry_index_o, .insert_status_o, .word_truncated_o);
endmodule

// ===== rtl/iix_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module iix_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/iix_front.sv =====
// front end: collects word bytes into a double buffer and queues closed words
`timescale 1ns / 1ps
module iix_front #(
  parameter int unsigned MaxWordChars = iix_pkg::MaxWordChars,
  localparam int unsigned CW = (MaxWordChars > 1) ? $clog2(MaxWordChars) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic [15:0]         doc_id_i,
  input  logic                last_char_i,
  output logic                buf_we_o,
  output logic [CW:0]         buf_waddr_o,
  output logic [7:0]          buf_wdata_o,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output iix_pkg::word_job_t  job_o,
  input  logic                bank_free_i
);
  logic [7:0]         len_q, len_d;
  logic               ovf_q, ovf_d;
  logic               bank_q, bank_d;
  logic               full_q, full_d;
  iix_pkg::word_job_t job_q, job_d;
  logic               acc, room;

  // front may only fill the bank that the back is not reading
  assign in_ready_o  = !full_q && bank_free_i;
  assign acc         = in_valid_i && in_ready_o;
  assign room        = len_q < 8'(MaxWordChars);
  assign buf_we_o    = acc && room;
  assign buf_waddr_o = {bank_q, len_q[CW-1:0]};
  assign buf_wdata_o = char_code_i;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    bank_d = bank_q;
    full_d = full_q;
    job_d  = job_q;
    if (full_q && job_ready_i) begin
      full_d = 1'b0;
    end
    if (acc) begin
      if (room) begin
        len_d = len_q + 8'd1;
      end else begin
        ovf_d = 1'b1;
      end
      if (last_char_i) begin
        job_d.doc_id    = doc_id_i;
        job_d.length    = room ? len_q + 8'd1 : len_q;
        job_d.truncated = ovf_q || !room;
        job_d.bank      = bank_q;
        full_d          = 1'b1;
        len_d           = '0;
        ovf_d           = 1'b0;
        bank_d          = !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end
endmodule

// ===== rtl/iix_back.sv =====
// back end: searches stored words, then the matched document list, and updates
`timescale 1ns / 1ps
module iix_back #(
  parameter int unsigned MaxEntries     = iix_pkg::MaxEntries,
  parameter int unsigned MaxWordChars   = iix_pkg::MaxWordChars,
  parameter int unsigned MaxDocsPerWord = iix_pkg::MaxDocsPerWord,
  localparam int unsigned EW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int unsigned CW = (MaxWordChars > 1) ? $clog2(MaxWordChars) : 1,
  localparam int unsigned DW = (MaxDocsPerWord > 1) ? $clog2(MaxDocsPerWord) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  iix_pkg::word_job_t job_i,
  output logic               busy_bank_o,
  output logic               busy_o,
  output logic [CW:0]        buf_raddr_o,
  input  logic [7:0]         buf_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         entry_index_o,
  output logic [2:0]         insert_status_o,
  output logic               word_truncated_o
);
  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SLen   = 9'b000000010,
    SLenW  = 9'b000000100,
    SCmp   = 9'b000001000,
    SDoc   = 9'b000010000,
    SCopy  = 9'b000100000,
    SWrite = 9'b001000000,
    SOut   = 9'b010000000,
    SDocW  = 9'b100000000
  } state_e;

  state_e             st_q, st_d;
  iix_pkg::word_job_t job_q, job_d;
  logic [EW:0]        cnt_q, cnt_d;
  logic [EW:0]        slot_q, slot_d;
  logic [7:0]         pos_q, pos_d;
  logic [7:0]         dcnt_q, dcnt_d;
  logic [2:0]         stat_q, stat_d;
  logic               ov_q, ov_d;
  logic [9:0]         oidx_q, oidx_d;
  logic               ovf_q, ovf_d;
  logic [9:0]         ridx_q, ridx_d;
  logic [2:0]         rstat_q, rstat_d;

  logic               len_we, cnt_we, ch_we, doc_we;
  logic [EW-1:0]      len_waddr, cnt_waddr;
  logic [7:0]         len_wdata, cnt_wdata, len_rdata, cnt_rdata, ch_rdata;
  logic [EW+CW-1:0]   ch_waddr, ch_raddr;
  logic [EW+DW-1:0]   doc_waddr, doc_raddr;
  logic [15:0]        doc_rdata;
  logic [EW-1:0]      slot_ix;

  assign slot_ix     = slot_q[EW-1:0];
  assign job_ready_o = st_q == SIdle;
  assign busy_o      = st_q != SIdle;
  assign busy_bank_o = job_q.bank;
  assign buf_raddr_o = {job_q.bank, pos_q[CW-1:0]};
  assign ch_raddr    = {slot_ix, pos_q[CW-1:0]};
  assign doc_raddr   = {slot_ix, pos_q[DW-1:0]};
  assign out_valid_o      = ov_q;
  assign entry_index_o    = ridx_q;
  assign insert_status_o  = rstat_q;
  assign word_truncated_o = ovf_q;

  iix_ram #(.Width(8), .Depth(MaxEntries)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(slot_ix), .rdata_o(len_rdata));
  iix_ram #(.Width(8), .Depth(MaxEntries)) u_dcnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(slot_ix), .rdata_o(cnt_rdata));
  iix_ram #(.Width(8), .Depth(MaxEntries * (1 << CW))) u_chars (
    .clk_i, .we_i(ch_we), .waddr_i(ch_waddr), .wdata_i(buf_rdata_i),
    .raddr_i(ch_raddr), .rdata_o(ch_rdata));
  iix_ram #(.Width(16), .Depth(MaxEntries * (1 << DW))) u_docs (
    .clk_i, .we_i(doc_we), .waddr_i(doc_waddr), .wdata_i(job_q.doc_id),
    .raddr_i(doc_raddr), .rdata_o(doc_rdata));

  // pipelined walk: address pos issued, data checked in the next cycle
  logic       chk_q, chk_d;
  logic [7:0] cpos_q, cpos_d;

  always_comb begin
    st_d = st_q; job_d = job_q; cnt_d = cnt_q; slot_d = slot_q; pos_d = pos_q;
    dcnt_d = dcnt_q; stat_d = stat_q; ov_d = ov_q; oidx_d = oidx_q; ovf_d = ovf_q;
    ridx_d = ridx_q; rstat_d = rstat_q;
    chk_d = 1'b0; cpos_d = pos_q;
    len_we = 1'b0; len_waddr = slot_ix; len_wdata = job_q.length;
    cnt_we = 1'b0; cnt_waddr = slot_ix; cnt_wdata = 8'd1;
    ch_we = 1'b0; ch_waddr = {slot_ix, cpos_q[CW-1:0]};
    doc_we = 1'b0; doc_waddr = {slot_ix, {DW{1'b0}}};
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      SIdle: begin
        if (job_valid_i) begin
          job_d  = job_i;
          slot_d = '0;
          st_d   = SLen;
        end
      end
      SLen: begin
        pos_d = '0;
        if (slot_q >= cnt_q) begin
          if (cnt_q >= (EW+1)'(MaxEntries)) begin
            stat_d = iix_pkg::StTableFull;
            oidx_d = '0;
            st_d   = SOut;
          end else begin
            st_d = SCopy;
          end
        end else begin
          st_d = SLenW;
        end
      end
      SLenW: begin
        if (len_rdata == job_q.length) begin
          st_d = SCmp;
        end else begin
          slot_d = slot_q + 1'b1;
          st_d   = SLen;
        end
      end
      SCmp: begin
        // compare stored bytes with the buffer one byte a cycle
        if (chk_q && ch_rdata != buf_rdata_i) begin
          slot_d = slot_q + 1'b1;
          st_d   = SLen;
        end else if (chk_q && cpos_q + 8'd1 >= job_q.length) begin
          pos_d  = '0;
          st_d   = SDocW;
        end else if (job_q.length == 8'd0) begin
          st_d = SDocW;
        end else begin
          chk_d  = 1'b1;
          cpos_d = pos_q;
          if (pos_q + 8'd1 < job_q.length) begin
            pos_d = pos_q + 8'd1;
          end
        end
      end
      SDocW: begin
        dcnt_d = cnt_rdata;
        pos_d  = '0;
        stat_d = iix_pkg::StAppended;
        st_d   = SDoc;
      end
      SDoc: begin
        if (chk_q && doc_rdata == job_q.doc_id) begin
          stat_d = iix_pkg::StPresent;
          oidx_d = 10'(slot_q);
          st_d   = SOut;
        end else if ((chk_q && cpos_q + 8'd1 >= dcnt_q) || dcnt_q == 8'd0) begin
          oidx_d = 10'(slot_q);
          st_d   = SOut;
          if (dcnt_q >= 8'(MaxDocsPerWord)) begin
            stat_d = iix_pkg::StListFull;
          end else begin
            doc_we    = 1'b1;
            doc_waddr = {slot_ix, dcnt_q[DW-1:0]};
            cnt_we    = 1'b1;
            cnt_wdata = dcnt_q + 8'd1;
          end
        end else begin
          chk_d  = 1'b1;
          cpos_d = pos_q;
          if (pos_q + 8'd1 < dcnt_q) begin
            pos_d = pos_q + 8'd1;
          end
        end
      end
      SCopy: begin
        // move buffered bytes into the new slot
        if (chk_q) begin
          ch_we = 1'b1;
        end
        if (job_q.length == 8'd0 || (chk_q && cpos_q + 8'd1 >= job_q.length)) begin
          st_d = SWrite;
        end else if (!chk_q || pos_q + 8'd1 < job_q.length) begin
          chk_d  = 1'b1;
          cpos_d = pos_q;
          if (chk_q) begin
            pos_d = pos_q + 8'd1;
            cpos_d = pos_q;
          end
        end
        if (chk_q && pos_q != cpos_q) begin
          cpos_d = pos_q;
          if (pos_q + 8'd1 < job_q.length) begin
            pos_d = pos_q + 8'd1;
          end
        end
      end
      SWrite: begin
        len_we = 1'b1;
        cnt_we = 1'b1;
        doc_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        stat_d = iix_pkg::StNew;
        oidx_d = 10'(slot_q);
        st_d   = SOut;
      end
      SOut: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          ovf_d   = job_q.truncated;
          ridx_d  = oidx_q;
          rstat_d = stat_q;
          st_d    = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SIdle;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      chk_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      chk_q <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    slot_q  <= slot_d;
    pos_q   <= pos_d;
    cpos_q  <= cpos_d;
    dcnt_q  <= dcnt_d;
    stat_q  <= stat_d;
    oidx_q  <= oidx_d;
    ovf_q   <= ovf_d;
    ridx_q  <= ridx_d;
    rstat_q <= rstat_d;
  end
endmodule

// ===== rtl/iix_checker.sv =====
// port checker for the inverted index insert block
`timescale 1ns / 1ps
`include "inverted_index_insert_defines.svh"
module iix_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [9:0]  entry_index_o,
  input logic [2:0]  insert_status_o
);
  `IIX_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, insert_status_o <= iix_pkg::StListFull)
  `IIX_ASSERT_IMP(a_full_slot0, clk_i, rst_ni, out_valid_o && insert_status_o == iix_pkg::StTableFull, entry_index_o == 10'd0)
  `IIX_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(entry_index_o) && $stable(insert_status_o))
endmodule

bind inverted_index_insert iix_checker u_chk (.*);
